[rtl/hsv2rgb_pkg.sv]
`default_nettype none

package hsv2rgb_pkg;

   // Width of one colour component and of the replaced-component mask
   localparam int unsigned CompW = 16;
   localparam int unsigned MaskW = 3;

   // Hue times six fits in this many bits for a 16-bit hue
   localparam int unsigned Hue6W = 19;

   // Highest sector that still mixes; it reuses the magenta-to-red mix
   localparam int unsigned SectorLast = 6;

   // Bit positions in the replaced-component mask
   localparam int unsigned MaskRed   = 0;
   localparam int unsigned MaskGreen = 1;
   localparam int unsigned MaskBlue  = 2;

   // One input pixel
   typedef struct packed {
      logic [CompW-1:0] hue;
      logic [CompW-1:0] saturation;
      logic [CompW-1:0] brightness;
   } hsv2rgb_req_type;

   // One output pixel
   typedef struct packed {
      logic [CompW-1:0] red;
      logic [CompW-1:0] green;
      logic [CompW-1:0] blue;
      logic [MaskW-1:0] replaced_mask;
   } hsv2rgb_rsp_type;

   // Hue sector, one sixth of the colour wheel each
   typedef enum logic [2:0] {
      SEC_RED_YELLOW   = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN   = 3'd2,
      SEC_CYAN_BLUE    = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED  = 3'd5
   } sector_type;

endpackage

`default_nettype wire

[rtl/hsv2rgb_sector.sv]
`default_nettype none

module hsv2rgb_sector #(
   parameter int unsigned FRAC_BITS = 15
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output      logic                               in_stall,
   input  wire hsv2rgb_pkg::hsv2rgb_req_type       in_data,
   output      logic                               out_valid,
   input  wire logic                               out_stall,
   output      logic [hsv2rgb_pkg::CompW-1:0]      out_sat,
   output      logic [hsv2rgb_pkg::CompW-1:0]      out_val,
   output      logic [FRAC_BITS-1:0]               out_frac,
   output      logic [FRAC_BITS:0]                 out_frac_c,
   output      logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+1:0] out_sat_c,
   output      hsv2rgb_pkg::sector_type            out_sector,
   output      logic                               out_gray
);
   import hsv2rgb_pkg::*;

   localparam int unsigned CW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
   localparam logic [FRAC_BITS:0] OneU = {1'b1, {FRAC_BITS{1'b0}}};

   logic [Hue6W-1:0]           hue6;
   logic [Hue6W+FRAC_BITS-1:0] hue6_ext;
   logic [Hue6W-1:0]           sector_raw;
   logic                       load;

   logic                       valid_ff;
   logic [CompW-1:0]           sat_ff, sat_in;
   logic [CompW-1:0]           val_ff, val_in;
   logic [FRAC_BITS-1:0]       frac_ff, frac_in;
   logic [FRAC_BITS:0]         frac_c_ff, frac_c_in;
   logic signed [CW-1:0]       sat_c_ff, sat_c_in;
   sector_type                 sector_ff, sector_in;
   logic                       gray_ff, gray_in;

   // Split hue times six into sector and fraction
   always_comb begin
      hue6       = (Hue6W'(in_data.hue) << 2) + (Hue6W'(in_data.hue) << 1);
      hue6_ext   = (Hue6W+FRAC_BITS)'(hue6);
      sector_raw = Hue6W'(hue6 >> FRAC_BITS);
      frac_in    = hue6_ext[FRAC_BITS-1:0];
      frac_c_in  = OneU - {1'b0, frac_in};
      sat_in     = in_data.saturation;
      val_in     = in_data.brightness;
      sat_c_in   = CW'(OneU) - CW'(in_data.saturation);
      gray_in    = (in_data.saturation == '0) || (sector_raw > Hue6W'(SectorLast));
      if (sector_raw == Hue6W'(SectorLast)) begin
         sector_in = SEC_MAGENTA_RED;
      end else begin
         sector_in = sector_type'(sector_raw[2:0]);
      end
   end

   // Advance when the stage is empty or its contents move on
   assign load     = !valid_ff || !out_stall;
   assign in_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         sat_ff    <= sat_in;
         val_ff    <= val_in;
         frac_ff   <= frac_in;
         frac_c_ff <= frac_c_in;
         sat_c_ff  <= sat_c_in;
         sector_ff <= sector_in;
         gray_ff   <= gray_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sat    = sat_ff;
   assign out_val    = val_ff;
   assign out_frac   = frac_ff;
   assign out_frac_c = frac_c_ff;
   assign out_sat_c  = sat_c_ff;
   assign out_sector = sector_ff;
   assign out_gray   = gray_ff;

endmodule

`default_nettype wire

[rtl/hsv2rgb_blend.sv]
`default_nettype none

module hsv2rgb_blend #(
   parameter int unsigned FRAC_BITS = 15
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output      logic                               in_stall,
   input  wire logic [hsv2rgb_pkg::CompW-1:0]      in_sat,
   input  wire logic [hsv2rgb_pkg::CompW-1:0]      in_val,
   input  wire logic [FRAC_BITS-1:0]               in_frac,
   input  wire logic [FRAC_BITS:0]                 in_frac_c,
   input  wire logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+1:0] in_sat_c,
   input  wire hsv2rgb_pkg::sector_type            in_sector,
   input  wire logic                               in_gray,
   output      logic                               out_valid,
   input  wire logic                               out_stall,
   output      logic [hsv2rgb_pkg::CompW-1:0]      out_val,
   output      hsv2rgb_pkg::sector_type            out_sector,
   output      logic                               out_gray,
   output      logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+18:0] out_v1,
   output      logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+18:0] out_prod_v2,
   output      logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+18:0] out_prod_v3
);
   import hsv2rgb_pkg::*;

   localparam int unsigned CW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
   localparam int unsigned PW = CW + 17;
   localparam int unsigned SW = CompW + FRAC_BITS + 2;
   localparam logic [FRAC_BITS:0]   OneU  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS-1:0] HalfU = {1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [PW-1:0] HalfP = PW'(HalfU);

   logic load2, load3, load4;

   // Stage two: saturation times fraction and (1 - f), brightness times (1 - s)
   logic                          valid2_ff;
   logic [CompW+FRAC_BITS-1:0]    prod_sf_ff, prod_sf_in;
   logic [CompW+FRAC_BITS:0]      prod_sfc_ff, prod_sfc_in;
   logic signed [PW-1:0]          prod_v1_ff, prod_v1_in;
   logic [CompW-1:0]              val2_ff;
   sector_type                    sector2_ff;
   logic                          gray2_ff;

   // Stage three: rounded mixing factors and v1
   logic                          valid3_ff;
   logic [SW-1:0]                 sf_sum, sfc_sum;
   logic [CompW-1:0]              sf, sfc;
   logic signed [PW-1:0]          v1_sum;
   logic signed [CW-1:0]          a2_ff, a2_in;
   logic signed [CW-1:0]          a3_ff, a3_in;
   logic signed [PW-1:0]          v1_3_ff, v1_3_in;
   logic [CompW-1:0]              val3_ff;
   sector_type                    sector3_ff;
   logic                          gray3_ff;

   // Stage four: brightness times the mixing factors
   logic                          valid4_ff;
   logic signed [PW-1:0]          prod_v2_ff, prod_v2_in;
   logic signed [PW-1:0]          prod_v3_ff, prod_v3_in;
   logic signed [PW-1:0]          v1_4_ff;
   logic [CompW-1:0]              val4_ff;
   sector_type                    sector4_ff;
   logic                          gray4_ff;

   // Advance each stage when it is empty or the one after it moves
   assign load4    = !valid4_ff || !out_stall;
   assign load3    = !valid3_ff || load4;
   assign load2    = !valid2_ff || load3;
   assign in_stall = !load2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (load2) begin
            valid2_ff <= in_valid;
         end
         if (load3) begin
            valid3_ff <= valid2_ff;
         end
         if (load4) begin
            valid4_ff <= valid3_ff;
         end
      end
   end

   // Multiply saturation by fraction and its complement, brightness by (1 - s)
   always_comb begin
      prod_sf_in  = (CompW+FRAC_BITS)'(in_sat) * (CompW+FRAC_BITS)'(in_frac);
      prod_sfc_in = (CompW+FRAC_BITS+1)'(in_sat) * (CompW+FRAC_BITS+1)'(in_frac_c);
      prod_v1_in  = $signed({1'b0, in_val}) * in_sat_c;
   end

   always_ff @(posedge clock) begin
      if (load2 && in_valid) begin
         prod_sf_ff  <= prod_sf_in;
         prod_sfc_ff <= prod_sfc_in;
         prod_v1_ff  <= prod_v1_in;
         val2_ff     <= in_val;
         sector2_ff  <= in_sector;
         gray2_ff    <= in_gray;
      end
   end

   // Round to nearest, ties up, and form the factors (1 - s*f) and (1 - s*(1-f))
   always_comb begin
      sf_sum  = SW'(prod_sf_ff) + SW'(HalfU);
      sfc_sum = SW'(prod_sfc_ff) + SW'(HalfU);
      sf      = sf_sum[FRAC_BITS+CompW-1:FRAC_BITS];
      sfc     = sfc_sum[FRAC_BITS+CompW-1:FRAC_BITS];
      a2_in   = CW'(OneU) - CW'(sf);
      a3_in   = CW'(OneU) - CW'(sfc);
      v1_sum  = prod_v1_ff + HalfP;
      v1_3_in = v1_sum >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (load3 && valid2_ff) begin
         a2_ff      <= a2_in;
         a3_ff      <= a3_in;
         v1_3_ff    <= v1_3_in;
         val3_ff    <= val2_ff;
         sector3_ff <= sector2_ff;
         gray3_ff   <= gray2_ff;
      end
   end

   // Multiply brightness by both factors
   always_comb begin
      prod_v2_in = $signed({1'b0, val3_ff}) * a2_ff;
      prod_v3_in = $signed({1'b0, val3_ff}) * a3_ff;
   end

   always_ff @(posedge clock) begin
      if (load4 && valid3_ff) begin
         prod_v2_ff <= prod_v2_in;
         prod_v3_ff <= prod_v3_in;
         v1_4_ff    <= v1_3_ff;
         val4_ff    <= val3_ff;
         sector4_ff <= sector3_ff;
         gray4_ff   <= gray3_ff;
      end
   end

   assign out_valid   = valid4_ff;
   assign out_val     = val4_ff;
   assign out_sector  = sector4_ff;
   assign out_gray    = gray4_ff;
   assign out_v1      = v1_4_ff;
   assign out_prod_v2 = prod_v2_ff;
   assign out_prod_v3 = prod_v3_ff;

endmodule

`default_nettype wire

[rtl/hsv2rgb_select.sv]
`default_nettype none

module hsv2rgb_select #(
   parameter int unsigned FRAC_BITS = 15
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output      logic                               in_stall,
   input  wire logic [hsv2rgb_pkg::CompW-1:0]      in_val,
   input  wire hsv2rgb_pkg::sector_type            in_sector,
   input  wire logic                               in_gray,
   input  wire logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+18:0] in_v1,
   input  wire logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+18:0] in_prod_v2,
   input  wire logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16)+18:0] in_prod_v3,
   output      logic                               out_valid,
   input  wire logic                               out_stall,
   output      hsv2rgb_pkg::hsv2rgb_rsp_type       out_data
);
   import hsv2rgb_pkg::*;

   localparam int unsigned CW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
   localparam int unsigned PW = CW + 17;
   localparam logic [FRAC_BITS:0]   OneU  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS-1:0] HalfU = {1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [PW-1:0] OneP  = PW'(OneU);
   localparam logic signed [PW-1:0] HalfP = PW'(HalfU);

   logic signed [PW-1:0] v2_sum, v3_sum;
   logic signed [PW-1:0] vv, v2, v3;
   logic signed [PW-1:0] red_c, green_c, blue_c;
   logic                 red_bad, green_bad, blue_bad;
   logic                 load;

   logic                 valid_ff;
   hsv2rgb_rsp_type      rsp_ff, rsp_in;

   // Round the last two products and pick the mix for the sector
   always_comb begin
      v2_sum = in_prod_v2 + HalfP;
      v3_sum = in_prod_v3 + HalfP;
      v2     = v2_sum >>> FRAC_BITS;
      v3     = v3_sum >>> FRAC_BITS;
      vv     = PW'(in_val);
      red_c   = vv;
      green_c = vv;
      blue_c  = vv;
      if (!in_gray) begin
         case (in_sector)
            SEC_RED_YELLOW: begin
               red_c = vv;    green_c = v3;    blue_c = in_v1;
            end
            SEC_YELLOW_GREEN: begin
               red_c = v2;    green_c = vv;    blue_c = in_v1;
            end
            SEC_GREEN_CYAN: begin
               red_c = in_v1; green_c = vv;    blue_c = v3;
            end
            SEC_CYAN_BLUE: begin
               red_c = in_v1; green_c = v2;    blue_c = vv;
            end
            SEC_BLUE_MAGENTA: begin
               red_c = v3;    green_c = in_v1; blue_c = vv;
            end
            SEC_MAGENTA_RED: begin
               red_c = vv;    green_c = in_v1; blue_c = v2;
            end
            default: begin
               red_c = vv;    green_c = vv;    blue_c = vv;
            end
         endcase
      end
   end

   // Zero and flag any component below zero or above one
   always_comb begin
      red_bad   = red_c[PW-1]   || (red_c > OneP);
      green_bad = green_c[PW-1] || (green_c > OneP);
      blue_bad  = blue_c[PW-1]  || (blue_c > OneP);
      rsp_in.red   = red_bad   ? '0 : red_c[CompW-1:0];
      rsp_in.green = green_bad ? '0 : green_c[CompW-1:0];
      rsp_in.blue  = blue_bad  ? '0 : blue_c[CompW-1:0];
      rsp_in.replaced_mask            = '0;
      rsp_in.replaced_mask[MaskRed]   = red_bad;
      rsp_in.replaced_mask[MaskGreen] = green_bad;
      rsp_in.replaced_mask[MaskBlue]  = blue_bad;
   end

   // Hold the result until the transfer completes
   assign load     = !valid_ff || !out_stall;
   assign in_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/hsv_to_rgb_convert.sv]
`default_nettype none

// Channel   Direction  Ports                          Payload
// request   in         req_valid, req_stall, req_data hue, saturation, brightness
// response  out        rsp_valid, rsp_stall, rsp_data red, green, blue, replaced_mask
//
// Takes one pixel every clock unless rsp_stall backs up to req_stall; each result
// passes the sector split, three multiply and round stages, then select and check.
// The two rows of multipliers set the depth; every stage holds a valid bit.
// Reset is synchronous and clears only the valid bits.
// A stall holds only the stages that are full, so empty stages keep filling.

module hsv_to_rgb_convert #(
   parameter int unsigned FRAC_BITS = 15
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire hsv2rgb_pkg::hsv2rgb_req_type   req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      hsv2rgb_pkg::hsv2rgb_rsp_type   rsp_data
);
   import hsv2rgb_pkg::*;

   localparam int unsigned CW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
   localparam int unsigned PW = CW + 17;

   // Sector stage to blend stages
   logic                   s1_valid, s1_stall;
   logic [CompW-1:0]       s1_sat, s1_val;
   logic [FRAC_BITS-1:0]   s1_frac;
   logic [FRAC_BITS:0]     s1_frac_c;
   logic signed [CW-1:0]   s1_sat_c;
   sector_type             s1_sector;
   logic                   s1_gray;

   // Blend stages to select stage
   logic                   s4_valid, s4_stall;
   logic [CompW-1:0]       s4_val;
   sector_type             s4_sector;
   logic                   s4_gray;
   logic signed [PW-1:0]   s4_v1, s4_prod_v2, s4_prod_v3;

   hsv2rgb_sector #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sector (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_data    (req_data),
      .out_valid  (s1_valid),
      .out_stall  (s1_stall),
      .out_sat    (s1_sat),
      .out_val    (s1_val),
      .out_frac   (s1_frac),
      .out_frac_c (s1_frac_c),
      .out_sat_c  (s1_sat_c),
      .out_sector (s1_sector),
      .out_gray   (s1_gray)
   );

   hsv2rgb_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_stall    (s1_stall),
      .in_sat      (s1_sat),
      .in_val      (s1_val),
      .in_frac     (s1_frac),
      .in_frac_c   (s1_frac_c),
      .in_sat_c    (s1_sat_c),
      .in_sector   (s1_sector),
      .in_gray     (s1_gray),
      .out_valid   (s4_valid),
      .out_stall   (s4_stall),
      .out_val     (s4_val),
      .out_sector  (s4_sector),
      .out_gray    (s4_gray),
      .out_v1      (s4_v1),
      .out_prod_v2 (s4_prod_v2),
      .out_prod_v3 (s4_prod_v3)
   );

   hsv2rgb_select #(
      .FRAC_BITS (FRAC_BITS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s4_valid),
      .in_stall   (s4_stall),
      .in_val     (s4_val),
      .in_sector  (s4_sector),
      .in_gray    (s4_gray),
      .in_v1      (s4_v1),
      .in_prod_v2 (s4_prod_v2),
      .in_prod_v3 (s4_prod_v3),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

endmodule

`default_nettype wire
